// File: hdl/pseq_pkg.sv
`timescale 1ns / 1ps

package pseq_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [CountW-1:0] PollLimitReset = 16'd5000;
  localparam logic [CountW-1:0] CountMax       = '1;

  // command kinds; the remaining codes are unknown and do nothing
  localparam logic [KindW-1:0] KIND_READ  = 3'd0;
  localparam logic [KindW-1:0] KIND_WRITE = 3'd1;
  localparam logic [KindW-1:0] KIND_POLL  = 3'd2;
  localparam logic [KindW-1:0] KIND_DELAY = 3'd3;
  localparam logic [KindW-1:0] KIND_END   = 3'd4;

  // bus request codes
  localparam logic [OpW-1:0] OP_NONE  = 2'd0;
  localparam logic [OpW-1:0] OP_READ  = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_NEXT    = 3'd0;
  localparam logic [StatusW-1:0] ST_AWAIT   = 3'd1;
  localparam logic [StatusW-1:0] ST_DONE    = 3'd2;
  localparam logic [StatusW-1:0] ST_TIMEOUT = 3'd3;
  localparam logic [StatusW-1:0] ST_ORDER   = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CUT       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAB       = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_INTF      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_POLLS = 2'd3;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_WRITE,
    PHASE_POLL
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic [AddrW-1:0]   pending_addr;
    logic [ByteW-1:0]   pending_value;
    logic [ByteW-1:0]   pending_mask;
    logic [CountW-1:0]  poll_count;
  } pseq_state_t;

  typedef struct packed {
    logic [ByteW-1:0]  cut_ver;
    logic [ByteW-1:0]  fab_version;
    logic [ByteW-1:0]  intf_ver;
    logic [CountW-1:0] max_polls;
  } pseq_cfg_t;

  typedef struct packed {
    logic              action;
    logic [KindW-1:0]  cmd_kind;
    logic [AddrW-1:0]  reg_offset;
    logic [ByteW-1:0]  cmd_value;
    logic [ByteW-1:0]  bit_mask;
    logic [ByteW-1:0]  fab_sel;
    logic [ByteW-1:0]  cut_sel;
    logic [ByteW-1:0]  intf_sel;
    logic [ByteW-1:0]  read_data;
  } pseq_item_t;

  typedef struct packed {
    logic [OpW-1:0]     bus_op;
    logic [AddrW-1:0]   bus_addr;
    logic [ByteW-1:0]   bus_wdata;
    logic [StatusW-1:0] status;
  } pseq_result_t;

endpackage

// File: hdl/pseq_item_if.sv
`timescale 1ns / 1ps

interface pseq_item_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [pseq_pkg::KindW-1:0]  cmd_kind;
  logic [pseq_pkg::AddrW-1:0]  reg_offset;
  logic [pseq_pkg::ByteW-1:0]  cmd_value;
  logic [pseq_pkg::ByteW-1:0]  bit_mask;
  logic [pseq_pkg::ByteW-1:0]  fab_sel;
  logic [pseq_pkg::ByteW-1:0]  cut_sel;
  logic [pseq_pkg::ByteW-1:0]  intf_sel;
  logic [pseq_pkg::ByteW-1:0]  read_data;

  modport source (
    output valid, action, cmd_kind, reg_offset, cmd_value, bit_mask,
           fab_sel, cut_sel, intf_sel, read_data,
    input  ready
  );

  modport sink (
    input  valid, action, cmd_kind, reg_offset, cmd_value, bit_mask,
           fab_sel, cut_sel, intf_sel, read_data,
    output ready
  );
endinterface

// File: hdl/pseq_result_if.sv
`timescale 1ns / 1ps

interface pseq_result_if;
  logic                          valid;
  logic                          ready;
  logic [pseq_pkg::OpW-1:0]      bus_op;
  logic [pseq_pkg::AddrW-1:0]    bus_addr;
  logic [pseq_pkg::ByteW-1:0]    bus_wdata;
  logic [pseq_pkg::StatusW-1:0]  status;

  modport source (
    output valid, bus_op, bus_addr, bus_wdata, status,
    input  ready
  );

  modport sink (
    input  valid, bus_op, bus_addr, bus_wdata, status,
    output ready
  );
endinterface

// File: hdl/pseq_step.sv
`timescale 1ns / 1ps

// One transaction's worth of sequencing: next state and the result it produces.
module pseq_step (
  input  pseq_pkg::pseq_state_t  state_i,
  input  pseq_pkg::pseq_cfg_t    cfg_i,
  input  pseq_pkg::pseq_item_t   item_i,
  output pseq_pkg::pseq_state_t  state_o,
  output pseq_pkg::pseq_result_t result_o
);
  import pseq_pkg::*;

  logic             applies;
  logic             poll_match;
  logic [ByteW-1:0] merged;

  assign applies = (|(item_i.fab_sel & cfg_i.fab_version)) &&
                   (|(item_i.cut_sel & cfg_i.cut_ver)) &&
                   (|(item_i.intf_sel & cfg_i.intf_ver));

  assign merged = (item_i.read_data & ~state_i.pending_mask) |
                  (state_i.pending_value & state_i.pending_mask);

  assign poll_match = (item_i.read_data & state_i.pending_mask) ==
                      (state_i.pending_value & state_i.pending_mask);

  always_comb begin
    state_o  = state_i;
    result_o = '{bus_op: OP_NONE, bus_addr: '0, bus_wdata: '0, status: ST_NEXT};

    if (!item_i.action) begin
      // command entry
      priority if (state_i.phase != PHASE_IDLE) begin
        result_o.status = ST_ORDER;
      end else if (!applies) begin
        result_o.status = ST_NEXT;
      end else if (item_i.cmd_kind == KIND_WRITE || item_i.cmd_kind == KIND_POLL) begin
        state_o.phase         = (item_i.cmd_kind == KIND_WRITE) ? PHASE_WRITE : PHASE_POLL;
        state_o.pending_addr  = item_i.reg_offset;
        state_o.pending_value = item_i.cmd_value;
        state_o.pending_mask  = item_i.bit_mask;
        result_o.bus_op       = OP_READ;
        result_o.bus_addr     = item_i.reg_offset;
        result_o.status       = ST_AWAIT;
      end else if (item_i.cmd_kind == KIND_END) begin
        state_o.poll_count = '0;
        result_o.status    = ST_DONE;
      end else begin
        // read, delay and unknown kinds
        result_o.status = ST_NEXT;
      end
    end else begin
      // bus read reply
      unique case (state_i.phase)
        PHASE_WRITE: begin
          state_o.phase      = PHASE_IDLE;
          result_o.bus_op    = OP_WRITE;
          result_o.bus_addr  = state_i.pending_addr;
          result_o.bus_wdata = merged;
          result_o.status    = ST_NEXT;
        end
        PHASE_POLL: begin
          if (state_i.poll_count > cfg_i.max_polls) begin
            state_o.phase      = PHASE_IDLE;
            state_o.poll_count = '0;
            result_o.status    = ST_TIMEOUT;
          end else begin
            if (state_i.poll_count != CountMax) begin
              state_o.poll_count = state_i.poll_count + 1'b1;
            end
            if (poll_match) begin
              state_o.phase   = PHASE_IDLE;
              result_o.status = ST_NEXT;
            end else begin
              result_o.bus_op   = OP_READ;
              result_o.bus_addr = state_i.pending_addr;
              result_o.status   = ST_AWAIT;
            end
          end
        end
        default: begin
          result_o.status = ST_ORDER;
        end
      endcase
    end
  end

endmodule

// File: hdl/power_sequence_command_engine.sv
`timescale 1ns / 1ps

// Power-sequence command engine. Each input transaction is either a command
// entry (action 0) or the byte returned by a bus read the engine requested
// (action 1); each produces exactly one result transaction carrying a bus
// request (none, read or write), its address, the merged write byte and a
// status. Writes are read-modify-write: the command issues a read, the reply
// produces the write. Polls re-issue the read until the masked byte matches
// or the sequence-wide poll count passes max_polls (checked before the count
// is incremented), which reports a timeout. An end command reports completion
// and clears the count. Timing: a transaction is registered at the input; its
// state update and result are computed into the result register once that is
// empty or draining. A new transaction can be accepted every cycle while the
// result side keeps taking results. Configuration registers are written through
// cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must do so only while no
// transaction is in flight, which the block itself does not enforce.
module power_sequence_command_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pseq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pseq_pkg::CfgW-1:0]    cfg_wdata_i,
  pseq_item_if.sink                    item_i,
  pseq_result_if.source                result_o
);
  import pseq_pkg::*;

  pseq_cfg_t    cfg_q;
  pseq_state_t  state_q, state_d;
  pseq_item_t   item_q;
  logic         item_vld_q;
  pseq_result_t res_q, res_d;
  logic         res_vld_q;
  logic         advance;
  logic         take;

  // the input stage moves on when the result register is empty or draining
  assign advance      = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !item_vld_q || advance;
  assign take         = item_i.valid && item_i.ready;

  pseq_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cut_ver     <= '0;
      cfg_q.fab_version <= '0;
      cfg_q.intf_ver    <= '0;
      cfg_q.max_polls   <= PollLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CUT:       cfg_q.cut_ver     <= cfg_wdata_i[ByteW-1:0];
        CFG_FAB:       cfg_q.fab_version <= cfg_wdata_i[ByteW-1:0];
        CFG_INTF:      cfg_q.intf_ver    <= cfg_wdata_i[ByteW-1:0];
        CFG_MAX_POLLS: cfg_q.max_polls   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // control: valid flags and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= '{phase: PHASE_IDLE, pending_addr: '0, pending_value: '0,
                      pending_mask: '0, poll_count: '0};
    end else begin
      if (item_i.ready) begin
        item_vld_q <= item_i.valid;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.action     <= item_i.action;
      item_q.cmd_kind   <= item_i.cmd_kind;
      item_q.reg_offset <= item_i.reg_offset;
      item_q.cmd_value  <= item_i.cmd_value;
      item_q.bit_mask   <= item_i.bit_mask;
      item_q.fab_sel    <= item_i.fab_sel;
      item_q.cut_sel    <= item_i.cut_sel;
      item_q.intf_sel   <= item_i.intf_sel;
      item_q.read_data  <= item_i.read_data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid     = res_vld_q;
  assign result_o.bus_op    = res_q.bus_op;
  assign result_o.bus_addr  = res_q.bus_addr;
  assign result_o.bus_wdata = res_q.bus_wdata;
  assign result_o.status    = res_q.status;

endmodule
